@@ src/tni_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package tni_pkg;

  typedef enum logic [1:0] {
    MODE_POS   = 2'd0,
    MODE_NRM   = 2'd1,
    MODE_TRI   = 2'd2,
    MODE_QUERY = 2'd3
  } mode_e;

  typedef struct packed {
    mode_e              mode;
    logic [9:0]         entry_index;
    logic signed [15:0] comp_x;
    logic signed [15:0] comp_y;
    logic signed [15:0] comp_z;
    logic [1:0]         corner;
    logic [9:0]         vertex_ref;
    logic [16:0]        bary_u;
    logic [16:0]        bary_v;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] normal_x;
    logic signed [15:0] normal_y;
    logic signed [15:0] normal_z;
    logic               smooth_used;
    logic               degenerate;
    logic [9:0]         queried_triangle;
  } out_item_t;

  typedef struct packed {
    logic       smooth;
    logic [9:0] tri_idx;
  } meta_t;

  typedef struct packed {
    logic       smooth;
    logic       degen;
    logic [9:0] tri_idx;
    logic [2:0] neg;
  } bctl_t;

  localparam int unsigned IDX_W      = 10;
  localparam int unsigned BARY_W     = 17;
  localparam logic [16:0] BARY_ONE   = 17'h10000;
  localparam int unsigned NRM_W      = 30;
  localparam int unsigned SQ_W       = 62;
  localparam int unsigned RT_W       = 64;
  localparam int unsigned LEN_W      = 31;
  localparam int unsigned SQRT_STEPS = 32;
  localparam int unsigned Q_W        = 15;
  localparam int unsigned DIV_STEPS  = 15;
  localparam int unsigned DIV_W      = 46;
  localparam int unsigned FRAC_BITS  = 14;
  localparam logic [14:0] UNIT       = 15'd16384;
  localparam int unsigned MQ_DEPTH   = 8;

endpackage
`default_nettype wire

@@ src/tni_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none
module tni_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

@@ src/tni_queue.sv @@
`timescale 1ns / 1ps
`default_nettype none
module tni_queue #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 8
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           push_i,
  input  logic [WIDTH-1:0]               data_i,
  input  logic                           pop_i,
  output logic [WIDTH-1:0]               data_o,
  output logic                           empty_o,
  output logic [$clog2(DEPTH+1)-1:0]     count_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [AW-1:0]    wr_q, wr_d, rd_q, rd_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic             do_pop;

  assign do_pop = pop_i && (cnt_q != '0);

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + AW'(1);
    end
    if (do_pop) begin
      rd_d = (rd_q == AW'(DEPTH - 1)) ? '0 : rd_q + AW'(1);
    end
    if (push_i && !do_pop) begin
      cnt_d = cnt_q + CW'(1);
    end else if (!push_i && do_pop) begin
      cnt_d = cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

  assign data_o  = mem_q[rd_q];
  assign empty_o = (cnt_q == '0);
  assign count_o = cnt_q;

endmodule
`default_nettype wire

@@ src/tni_front.sv @@
`timescale 1ns / 1ps
`default_nettype none
module tni_front #(
  parameter int unsigned MAX_VERTICES  = 1024,
  parameter int unsigned MAX_TRIANGLES = 1024,
  parameter int unsigned COORD_BITS    = 16,
  parameter int unsigned VW            = 35
) (
  input  logic                                       clk_i,
  input  logic                                       rst_ni,
  input  logic                                       push_i,
  input  tni_pkg::in_item_t                          item_i,
  output logic                                       full_o,
  input  logic                                       normals_present_i,
  input  logic [$clog2(tni_pkg::MQ_DEPTH+1)-1:0]     q_count_i,
  output logic                                       q_push_o,
  output logic [2:0][VW-1:0]                         vec_o,
  output tni_pkg::meta_t                             meta_o
);

  localparam int unsigned C   = COORD_BITS;
  localparam int unsigned AWV = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int unsigned AWT = (MAX_TRIANGLES > 1) ? $clog2(MAX_TRIANGLES) : 1;
  localparam int unsigned BW  = tni_pkg::BARY_W;
  localparam int unsigned IW  = tni_pkg::IDX_W;
  localparam int unsigned PW  = C + BW + 1;
  localparam int unsigned EW  = C + 1;
  localparam int unsigned FW  = 2 * C + 2;
  localparam int unsigned CW  = $clog2(tni_pkg::MQ_DEPTH + 1);

  logic          acc, idx_v_ok, idx_t_ok, is_query;
  logic [BW-1:0] u_sat, v_lim, v_sat, w_sat;
  logic [3*C-1:0] wr_word;
  logic [IW-1:0] tri_rd [3];
  logic [3*C-1:0] pos_rd [3];
  logic [3*C-1:0] nrm_rd [3];
  logic [IW-1:0] ref_d [3];
  logic [2:0]    ref_ok;

  assign acc      = push_i && !full_o;
  assign idx_v_ok = 32'(item_i.entry_index) < MAX_VERTICES;
  assign idx_t_ok = 32'(item_i.entry_index) < MAX_TRIANGLES;
  assign is_query = item_i.mode == tni_pkg::MODE_QUERY;
  assign wr_word  = {C'(item_i.comp_z), C'(item_i.comp_y), C'(item_i.comp_x)};

  always_comb begin
    u_sat = (item_i.bary_u > tni_pkg::BARY_ONE) ? tni_pkg::BARY_ONE : item_i.bary_u;
    v_lim = tni_pkg::BARY_ONE - u_sat;
    v_sat = (item_i.bary_v > v_lim) ? v_lim : item_i.bary_v;
    w_sat = v_lim - v_sat;
  end

  // S1: triangle corners read
  logic          v1_q, tok1_q, sm1_q;
  logic [IW-1:0] idx1_q;
  logic [BW-1:0] u1_q, vv1_q, w1_q;
  // S2: vertex rows read
  logic          v2_q, tok2_q, sm2_q;
  logic [IW-1:0] idx2_q;
  logic [BW-1:0] u2_q, vv2_q, w2_q;
  logic [2:0]    rok2_q;
  // S3: products
  logic          v3_q, tok3_q, sm3_q;
  logic [IW-1:0] idx3_q;
  logic signed [PW-1:0] sp3_q [3][3];
  logic signed [FW-1:0] fp3_q [6];

  for (genvar k = 0; k < 3; k++) begin : g_store
    tni_ram #(.WIDTH(IW), .DEPTH(MAX_TRIANGLES), .AW(AWT)) u_tri (
      .clk_i  (clk_i),
      .we_i   (acc && item_i.mode == tni_pkg::MODE_TRI && idx_t_ok && item_i.corner == 2'(k)),
      .waddr_i(AWT'(item_i.entry_index)),
      .wdata_i(item_i.vertex_ref),
      .raddr_i(AWT'(item_i.entry_index)),
      .rdata_o(tri_rd[k])
    );
    tni_ram #(.WIDTH(3 * C), .DEPTH(MAX_VERTICES), .AW(AWV)) u_pos (
      .clk_i  (clk_i),
      .we_i   (acc && item_i.mode == tni_pkg::MODE_POS && idx_v_ok),
      .waddr_i(AWV'(item_i.entry_index)),
      .wdata_i(wr_word),
      .raddr_i(AWV'(ref_d[k])),
      .rdata_o(pos_rd[k])
    );
    tni_ram #(.WIDTH(3 * C), .DEPTH(MAX_VERTICES), .AW(AWV)) u_nrm (
      .clk_i  (clk_i),
      .we_i   (acc && item_i.mode == tni_pkg::MODE_NRM && idx_v_ok),
      .waddr_i(AWV'(item_i.entry_index)),
      .wdata_i(wr_word),
      .raddr_i(AWV'(ref_d[k])),
      .rdata_o(nrm_rd[k])
    );
    assign ref_d[k]  = tri_rd[k];
    assign ref_ok[k] = 32'(tri_rd[k]) < MAX_VERTICES;
  end

  logic signed [C-1:0]  pc [3][3];
  logic signed [C-1:0]  nc [3][3];
  logic signed [EW-1:0] e0 [3];
  logic signed [EW-1:0] e1 [3];
  logic signed [BW:0]   wt [3];
  logic signed [PW-1:0] sp [3][3];
  logic signed [FW-1:0] fp [6];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      for (int j = 0; j < 3; j++) begin
        pc[k][j] = rok2_q[k] ? $signed(pos_rd[k][j*C +: C]) : '0;
        nc[k][j] = rok2_q[k] ? $signed(nrm_rd[k][j*C +: C]) : '0;
      end
    end
    for (int j = 0; j < 3; j++) begin
      e0[j] = EW'(pc[1][j]) - EW'(pc[0][j]);
      e1[j] = EW'(pc[2][j]) - EW'(pc[0][j]);
    end
    wt[0] = $signed({1'b0, w2_q});
    wt[1] = $signed({1'b0, u2_q});
    wt[2] = $signed({1'b0, vv2_q});
    for (int j = 0; j < 3; j++) begin
      for (int k = 0; k < 3; k++) begin
        sp[j][k] = wt[k] * nc[k][j];
      end
    end
    fp[0] = e0[1] * e1[2];
    fp[1] = e0[2] * e1[1];
    fp[2] = e0[2] * e1[0];
    fp[3] = e0[0] * e1[2];
    fp[4] = e0[0] * e1[1];
    fp[5] = e0[1] * e1[0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= acc && is_query;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    tok1_q <= idx_t_ok;
    sm1_q  <= normals_present_i;
    idx1_q <= item_i.entry_index;
    u1_q   <= u_sat;
    vv1_q  <= v_sat;
    w1_q   <= w_sat;
    tok2_q <= tok1_q;
    sm2_q  <= sm1_q;
    idx2_q <= idx1_q;
    u2_q   <= u1_q;
    vv2_q  <= vv1_q;
    w2_q   <= w1_q;
    rok2_q <= ref_ok;
    tok3_q <= tok2_q;
    sm3_q  <= sm2_q;
    idx3_q <= idx2_q;
    sp3_q  <= sp;
    fp3_q  <= fp;
  end

  logic signed [VW-1:0] vec [3];

  always_comb begin
    if (sm3_q) begin
      for (int j = 0; j < 3; j++) begin
        vec[j] = VW'(sp3_q[j][0]) + VW'(sp3_q[j][1]) + VW'(sp3_q[j][2]);
      end
    end else begin
      vec[0] = VW'(fp3_q[0]) - VW'(fp3_q[1]);
      vec[1] = VW'(fp3_q[2]) - VW'(fp3_q[3]);
      vec[2] = VW'(fp3_q[4]) - VW'(fp3_q[5]);
    end
    for (int j = 0; j < 3; j++) begin
      vec_o[j] = tok3_q ? vec[j] : '0;
    end
  end

  assign q_push_o       = v3_q;
  assign meta_o.smooth  = sm3_q;
  assign meta_o.tri_idx = idx3_q;

  // hold new items while the queue cannot take every query in flight
  assign full_o = ({1'b0, q_count_i} + (CW+1)'(v1_q) + (CW+1)'(v2_q) + (CW+1)'(v3_q))
                  >= (CW+1)'(tni_pkg::MQ_DEPTH);

endmodule
`default_nettype wire

@@ src/tni_back.sv @@
`timescale 1ns / 1ps
`default_nettype none
module tni_back #(
  parameter int unsigned VW = 35
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 q_empty_i,
  output logic                 q_pop_o,
  input  logic [2:0][VW-1:0]   vec_i,
  input  tni_pkg::meta_t       meta_i,
  output logic                 empty_o,
  input  logic                 pop_i,
  output tni_pkg::out_item_t   item_o
);

  localparam int unsigned NW   = tni_pkg::NRM_W;
  localparam int unsigned MW   = (VW > NW) ? VW : NW;
  localparam int unsigned NSH  = $clog2(MW);
  localparam int unsigned NRT  = tni_pkg::SQRT_STEPS;
  localparam int unsigned NDV  = tni_pkg::DIV_STEPS;
  localparam int unsigned RW   = tni_pkg::RT_W;
  localparam int unsigned DW   = tni_pkg::DIV_W;
  localparam int unsigned LW   = tni_pkg::LEN_W;
  localparam int unsigned QW   = tni_pkg::Q_W;
  localparam int unsigned NSTG = 2 + NSH + 2 + NRT + 1 + NDV;

  logic             en, out_valid_q;
  logic [NSTG-1:0]  v_q;
  tni_pkg::bctl_t   ctl_q [NSTG];
  tni_pkg::out_item_t out_q;

  assign en      = !(v_q[NSTG-1] && out_valid_q && !pop_i);
  assign q_pop_o = en && !q_empty_i;

  // stage A: magnitudes
  logic [MW-1:0] mag_a_q [3];
  logic [MW-1:0] mag_a_d [3];
  logic [2:0]    neg_a;
  logic signed [VW:0] ext [3];
  logic [VW:0]   absv [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      neg_a[k]   = vec_i[k][VW-1];
      ext[k]     = {vec_i[k][VW-1], vec_i[k]};
      absv[k]    = neg_a[k] ? $unsigned(-ext[k]) : $unsigned(ext[k]);
      mag_a_d[k] = MW'(absv[k]);
    end
  end

  // stage B: largest magnitude
  logic [MW-1:0] mx_a;

  always_comb begin
    mx_a = mag_a_q[0];
    if (mag_a_q[1] > mx_a) begin
      mx_a = mag_a_q[1];
    end
    if (mag_a_q[2] > mx_a) begin
      mx_a = mag_a_q[2];
    end
  end

  logic [MW-1:0] mx_s_q  [NSH+1];
  logic [MW-1:0] mag_s_q [NSH+1][3];

  always_ff @(posedge clk_i) begin
    if (en) begin
      mag_a_q      <= mag_a_d;
      mx_s_q[0]    <= mx_a;
      mag_s_q[0]   <= mag_a_q;
    end
  end

  // left-normalize so the largest magnitude has its top bit set
  for (genvar j = 0; j < NSH; j++) begin : g_norm
    localparam int unsigned AMT = 1 << (NSH - 1 - j);
    logic go;
    assign go = (mx_s_q[j][MW-1 -: AMT] == '0);
    always_ff @(posedge clk_i) begin
      if (en) begin
        mx_s_q[j+1] <= go ? (mx_s_q[j] << AMT) : mx_s_q[j];
        for (int k = 0; k < 3; k++) begin
          mag_s_q[j+1][k] <= go ? (mag_s_q[j][k] << AMT) : mag_s_q[j][k];
        end
      end
    end
  end

  // squares, then their sum
  logic [NW-1:0]   m30_q [3];
  logic [2*NW-1:0] sq_q [3];
  logic [RW-1:0]   x_q [NRT+1];
  logic [RW-1:0]   r_q [NRT+1];
  logic [NW-1:0]   m30_r_q [NRT+1][3];

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        m30_q[k] <= mag_s_q[NSH][k][MW-1 -: NW];
        sq_q[k]  <= mag_s_q[NSH][k][MW-1 -: NW] * mag_s_q[NSH][k][MW-1 -: NW];
      end
      x_q[0]     <= RW'(tni_pkg::SQ_W'(sq_q[0]) + tni_pkg::SQ_W'(sq_q[1])
                        + tni_pkg::SQ_W'(sq_q[2]));
      r_q[0]     <= '0;
      m30_r_q[0] <= m30_q;
    end
  end

  // square root, one result bit per stage
  for (genvar i = 0; i < NRT; i++) begin : g_root
    localparam logic [RW-1:0] RBIT = RW'(1) << (2 * (NRT - 1 - i));
    logic [RW-1:0] trial;
    assign trial = r_q[i] + RBIT;
    always_ff @(posedge clk_i) begin
      if (en) begin
        if (x_q[i] >= trial) begin
          x_q[i+1] <= x_q[i] - trial;
          r_q[i+1] <= (r_q[i] >> 1) + RBIT;
        end else begin
          x_q[i+1] <= x_q[i];
          r_q[i+1] <= r_q[i] >> 1;
        end
        m30_r_q[i+1] <= m30_r_q[i];
      end
    end
  end

  // rounded quotient, one bit per stage
  logic [DW-1:0] rem_q [NDV+1][3];
  logic [QW-1:0] quo_q [NDV+1][3];
  logic [LW-1:0] len_q [NDV+1];
  logic [LW-1:0] len_n;

  assign len_n = LW'(r_q[NRT]);

  always_ff @(posedge clk_i) begin
    if (en) begin
      len_q[0] <= len_n;
      for (int k = 0; k < 3; k++) begin
        rem_q[0][k] <= (DW'(m30_r_q[NRT][k]) << tni_pkg::FRAC_BITS) + DW'(len_n >> 1);
        quo_q[0][k] <= '0;
      end
    end
  end

  for (genvar d = 0; d < NDV; d++) begin : g_div
    localparam int unsigned SH = NDV - 1 - d;
    logic [DW-1:0] dvs;
    assign dvs = DW'(len_q[d]) << SH;
    always_ff @(posedge clk_i) begin
      if (en) begin
        len_q[d+1] <= len_q[d];
        for (int k = 0; k < 3; k++) begin
          if (rem_q[d][k] >= dvs) begin
            rem_q[d+1][k] <= rem_q[d][k] - dvs;
            quo_q[d+1][k] <= quo_q[d][k] | (QW'(1) << SH);
          end else begin
            rem_q[d+1][k] <= rem_q[d][k];
            quo_q[d+1][k] <= quo_q[d][k];
          end
        end
      end
    end
  end

  // control travels alongside the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[NSTG-2:0], q_pop_o};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ctl_q[0].smooth  <= meta_i.smooth;
      ctl_q[0].tri_idx <= meta_i.tri_idx;
      ctl_q[0].neg     <= neg_a;
      ctl_q[0].degen   <= 1'b0;
      ctl_q[1].smooth  <= ctl_q[0].smooth;
      ctl_q[1].tri_idx <= ctl_q[0].tri_idx;
      ctl_q[1].neg     <= ctl_q[0].neg;
      ctl_q[1].degen   <= (mx_a == '0);
      for (int i = 2; i < NSTG; i++) begin
        ctl_q[i] <= ctl_q[i-1];
      end
    end
  end

  logic [QW-1:0]      qc [3];
  logic signed [15:0] nv [3];
  tni_pkg::out_item_t res;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      qc[k] = (quo_q[NDV][k] > tni_pkg::UNIT) ? tni_pkg::UNIT : quo_q[NDV][k];
      if (ctl_q[NSTG-1].degen) begin
        nv[k] = '0;
      end else if (ctl_q[NSTG-1].neg[k]) begin
        nv[k] = -$signed(16'(qc[k]));
      end else begin
        nv[k] = $signed(16'(qc[k]));
      end
    end
    res.normal_x         = nv[0];
    res.normal_y         = nv[1];
    res.normal_z         = nv[2];
    res.smooth_used      = ctl_q[NSTG-1].smooth;
    res.degenerate       = ctl_q[NSTG-1].degen;
    res.queried_triangle = ctl_q[NSTG-1].tri_idx;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (v_q[NSTG-1] && en) begin
      out_valid_q <= 1'b1;
    end else if (pop_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (v_q[NSTG-1] && en) begin
      out_q <= res;
    end
  end

  assign empty_o = !out_valid_q;
  assign item_o  = out_q;

endmodule
`default_nettype wire

@@ src/triangle_normal_interpolator.sv @@
`timescale 1ns / 1ps
`default_nettype none
// A query passes the front stages and the queue, then the 58 back stages at COORD_BITS 16,
// dominated by the 32-stage square root, and then the output register.
// Throughput: one item per cycle while full is low; writes take effect for items accepted
// in the next cycle. Reset clears normals_present, the queue and all pipeline valid bits;
// store contents are undefined until written.
module triangle_normal_interpolator #(
  parameter int unsigned MAX_VERTICES  = 1024,
  parameter int unsigned MAX_TRIANGLES = 1024,
  parameter int unsigned COORD_BITS    = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  input  tni_pkg::in_item_t  in_item_i,
  output logic               full,
  output logic               empty,
  input  logic               pop,
  output tni_pkg::out_item_t out_item_o,
  input  logic               cfg_we_i,
  input  logic               cfg_wdata_i
);

  localparam int unsigned VW = (2 * COORD_BITS + 3 > COORD_BITS + 18) ?
                               2 * COORD_BITS + 3 : COORD_BITS + 18;
  localparam int unsigned MB = $bits(tni_pkg::meta_t);
  localparam int unsigned QW = 3 * VW + MB;
  localparam int unsigned CW = $clog2(tni_pkg::MQ_DEPTH + 1);

  logic               normals_present_q;
  logic               q_push, q_pop, q_empty;
  logic [CW-1:0]      q_count;
  logic [2:0][VW-1:0] f_vec, b_vec;
  tni_pkg::meta_t     f_meta, b_meta;
  logic [QW-1:0]      q_wdata, q_rdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      normals_present_q <= 1'b0;
    end else if (cfg_we_i) begin
      normals_present_q <= cfg_wdata_i;
    end
  end

  tni_front #(
    .MAX_VERTICES (MAX_VERTICES),
    .MAX_TRIANGLES(MAX_TRIANGLES),
    .COORD_BITS   (COORD_BITS),
    .VW           (VW)
  ) u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .push_i           (push),
    .item_i           (in_item_i),
    .full_o           (full),
    .normals_present_i(normals_present_q),
    .q_count_i        (q_count),
    .q_push_o         (q_push),
    .vec_o            (f_vec),
    .meta_o           (f_meta)
  );

  assign q_wdata = {f_meta, f_vec};

  tni_queue #(.WIDTH(QW), .DEPTH(tni_pkg::MQ_DEPTH)) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .data_i (q_wdata),
    .pop_i  (q_pop),
    .data_o (q_rdata),
    .empty_o(q_empty),
    .count_o(q_count)
  );

  assign b_vec  = q_rdata[3*VW-1:0];
  assign b_meta = q_rdata[QW-1 -: MB];

  tni_back #(.VW(VW)) u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .q_empty_i(q_empty),
    .q_pop_o  (q_pop),
    .vec_i    (b_vec),
    .meta_i   (b_meta),
    .empty_o  (empty),
    .pop_i    (pop),
    .item_o   (out_item_o)
  );

endmodule
`default_nettype wire
